### hw/rtl/mrf_pkg.sv
// Package for the Modbus RTU request framer: beat and command types,
// protocol constants and the CRC-16 byte update. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrf_pkg;

	localparam logic [7:0]  FUNC_READ_CODE  = 8'h03;
	localparam logic [7:0]  FUNC_WRITE_CODE = 8'h10;
	localparam logic [7:0]  READ_MAX_COUNT  = 8'd125;
	localparam logic [7:0]  WRITE_MAX_COUNT = 8'd123;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [7:0]  SLAVE_ADDR_RST  = 8'd1;
	localparam logic [3:0]  IDX_HEAD_START  = 4'd0;
	localparam logic [3:0]  IDX_WDATA_START = 4'd7;

	typedef struct packed {
		logic        func;
		logic [15:0] reg_offset;
		logic [7:0]  reg_count;
		logic [15:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       frame_last;
		logic       rejected;
	} out_item_t;

	// Command kinds handed from the front to the back
	typedef enum logic [1:0] {
		KIND_REJECT = 2'd0,
		KIND_READ   = 2'd1,
		KIND_WHEAD  = 2'd2,
		KIND_WDATA  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        crc_end;
		logic [7:0]  slave_addr;
		logic [15:0] reg_offset;
		logic [7:0]  reg_count;
		logic [15:0] data_word;
	} cmd_t;

	// What the byte sequencer puts on the wire in a given slot
	typedef enum logic [3:0] {
		SEL_ADDR = 4'd0,
		SEL_FUNC = 4'd1,
		SEL_OFFH = 4'd2,
		SEL_OFFL = 4'd3,
		SEL_ZERO = 4'd4,
		SEL_CNT  = 4'd5,
		SEL_BCNT = 4'd6,
		SEL_WH   = 4'd7,
		SEL_WL   = 4'd8,
		SEL_CRCL = 4'd9,
		SEL_CRCH = 4'd10,
		SEL_REJ  = 4'd11
	} sel_t;

	// Modbus CRC-16, one byte, reflected
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/mrf_front.sv
// Front of the request framer: takes input beats, checks the count,
// tracks the open write frame and builds commands. Depends on mrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrf_front (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic cfg_we,
	input  wire                logic [7:0] cfg_wdata,
	input  wire                logic accept,
	input  mrf_pkg::in_item_t  item,
	output mrf_pkg::cmd_t      cmd
);
	import mrf_pkg::*;

	logic [7:0] slave_addr_q;
	logic       in_write_q;
	logic [6:0] words_left_q;
	logic [7:0] limit;
	logic       bad_count;
	logic [6:0] words_dec;

	assign limit     = item.func ? WRITE_MAX_COUNT : READ_MAX_COUNT;
	assign bad_count = (item.reg_count == 8'd0) || (item.reg_count > limit);
	assign words_dec = words_left_q - 7'd1;

	always_comb begin
		cmd.slave_addr = slave_addr_q;
		cmd.reg_offset = item.reg_offset;
		cmd.reg_count  = item.reg_count;
		cmd.data_word  = item.data_word;
		cmd.crc_end    = 1'b0;
		priority if (in_write_q) begin
			cmd.kind    = KIND_WDATA;
			cmd.crc_end = (words_dec == 7'd0);
		end else if (bad_count) begin
			cmd.kind = KIND_REJECT;
		end else if (!item.func) begin
			cmd.kind    = KIND_READ;
			cmd.crc_end = 1'b1;
		end else begin
			cmd.kind    = KIND_WHEAD;
			cmd.crc_end = (item.reg_count == 8'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RST;
		end else if (cfg_we) begin
			slave_addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_write_q   <= 1'b0;
			words_left_q <= 7'd0;
		end else if (accept) begin
			if (cmd.kind == KIND_WDATA) begin
				words_left_q <= words_dec;
				in_write_q   <= !cmd.crc_end;
			end else if (cmd.kind == KIND_WHEAD && !cmd.crc_end) begin
				words_left_q <= item.reg_count[6:0] - 7'd1;
				in_write_q   <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/mrf_cmd_queue.sv
// Short command queue between the framer front and back.
// Depends on mrf_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module mrf_cmd_queue #(
	parameter int DEPTH = 2
) (
	input  wire            logic clk,
	input  wire            logic arst_n,
	input  wire            logic push,
	input  mrf_pkg::cmd_t  push_cmd,
	output logic           full,
	input  wire            logic pop,
	output logic           not_empty,
	output mrf_pkg::cmd_t  head
);
	import mrf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/mrf_back.sv
// Back of the request framer: byte sequencer, running CRC-16 and the
// output beat register. Depends on mrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrf_back (
	input  wire               logic clk,
	input  wire               logic arst_n,
	input  wire               logic cmd_avail,
	input  mrf_pkg::cmd_t     cmd_head,
	output logic              cmd_pop,
	output logic              out_valid,
	input  wire               logic out_stall,
	output mrf_pkg::out_item_t out_data
);
	import mrf_pkg::*;

	cmd_t        cmd_q;
	logic        active_q;
	logic [3:0]  idx_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	out_item_t   out_q;

	sel_t        sel;
	logic [7:0]  byte_val;
	logic        out_room;
	logic        emit;
	logic        done;
	logic        is_crc_end;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		if (cmd_q.kind == KIND_REJECT) begin
			sel = SEL_REJ;
		end else begin
			unique case (idx_q)
				4'd0:    sel = SEL_ADDR;
				4'd1:    sel = SEL_FUNC;
				4'd2:    sel = SEL_OFFH;
				4'd3:    sel = SEL_OFFL;
				4'd4:    sel = SEL_ZERO;
				4'd5:    sel = SEL_CNT;
				4'd6:    sel = (cmd_q.kind == KIND_READ) ? SEL_CRCL : SEL_BCNT;
				4'd7:    sel = (cmd_q.kind == KIND_READ) ? SEL_CRCH : SEL_WH;
				4'd8:    sel = SEL_WL;
				4'd9:    sel = SEL_CRCL;
				default: sel = SEL_CRCH;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			SEL_ADDR: byte_val = cmd_q.slave_addr;
			SEL_FUNC: byte_val = (cmd_q.kind == KIND_READ) ? FUNC_READ_CODE : FUNC_WRITE_CODE;
			SEL_OFFH: byte_val = cmd_q.reg_offset[15:8];
			SEL_OFFL: byte_val = cmd_q.reg_offset[7:0];
			SEL_CNT:  byte_val = cmd_q.reg_count;
			SEL_BCNT: byte_val = {cmd_q.reg_count[6:0], 1'b0};
			SEL_WH:   byte_val = cmd_q.data_word[15:8];
			SEL_WL:   byte_val = cmd_q.data_word[7:0];
			SEL_CRCL: byte_val = crc_q[7:0];
			SEL_CRCH: byte_val = crc_q[15:8];
			default:  byte_val = 8'h00;
		endcase
	end

	assign is_crc_end = (sel == SEL_CRCH) || (sel == SEL_REJ);
	assign out_room   = !out_valid_q || !out_stall;
	assign emit       = active_q && out_room;
	assign done       = emit && (is_crc_end || (sel == SEL_WL && !cmd_q.crc_end));
	assign cmd_pop    = cmd_avail && (!active_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= IDX_HEAD_START;
		end else if (cmd_pop) begin
			active_q <= 1'b1;
			idx_q    <= (cmd_head.kind == KIND_WDATA) ? IDX_WDATA_START : IDX_HEAD_START;
		end else if (done) begin
			active_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_head;
		end
	end

	// Restart at the address byte; hold across the data words of a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (emit) begin
			priority if (sel == SEL_ADDR) begin
				crc_q <= crc_feed(CRC_INIT, byte_val);
			end else if (sel == SEL_CRCH) begin
				crc_q <= CRC_INIT;
			end else if (sel != SEL_CRCL && sel != SEL_REJ) begin
				crc_q <= crc_feed(crc_q, byte_val);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_room) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.tx_byte    <= byte_val;
			out_q.frame_last <= is_crc_end;
			out_q.rejected   <= (sel == SEL_REJ);
		end
	end

endmodule

`default_nettype wire

### hw/rtl/modbus_rtu_request_framer_unit.sv
// Top level of the Modbus RTU request framer: front, command queue, back.
// Depends on mrf_pkg, mrf_front, mrf_cmd_queue and mrf_back.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------
//   in       | in_valid / in_stall | in_data   (func, offset, count, word)
//   out      | out_valid/out_stall | out_data  (tx_byte, last, rejected)
//   cfg      | cfg_we              | cfg_wdata (slave address)
//
// Each item gives one output beat per frame byte, one beat per cycle from
// the back's byte sequencer while out is not stalled: 1 (reject), 2 or 4 (write data
// word, with CRC on the last), 8 (read), 9 or 11 (write header) beats.
// The front takes a beat whenever the command queue has room, so items
// enter back to back while the back still streams earlier frames.
// Reset clears the queue, the open-frame state and the output register;
// the slave address returns to 1.
// A stall on out holds the output beat; the queue fills behind it and
// then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_request_framer_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire                 logic clk,
	input  wire                 logic arst_n,
	input  wire                 logic in_valid,
	output logic                in_stall,
	input  mrf_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  wire                 logic out_stall,
	output mrf_pkg::out_item_t  out_data,
	input  wire                 logic cfg_we,
	input  wire                 logic [7:0] cfg_wdata
);
	import mrf_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic q_full;
	logic q_avail;
	logic q_pop;
	logic in_accept;

	// Accept a beat whenever the queue can take its command
	assign in_stall  = q_full;
	assign in_accept = in_valid && !q_full;

	mrf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (in_accept),
		.item      (in_data),
		.cmd       (front_cmd)
	);

	mrf_cmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept),
		.push_cmd  (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_avail),
		.head      (head_cmd)
	);

	mrf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (q_avail),
		.cmd_head  (head_cmd),
		.cmd_pop   (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

### hw/rtl/mrf_checker.sv
// Port-level checks for the Modbus RTU request framer, bound to the top.
// Depends on mrf_pkg and modbus_rtu_request_framer_unit.
`timescale 1ns / 1ps
`default_nettype none

module mrf_checker (
	input wire                logic clk,
	input wire                logic arst_n,
	input wire                logic in_valid,
	input wire                logic in_stall,
	input mrf_pkg::in_item_t  in_data,
	input wire                logic out_valid,
	input wire                logic out_stall,
	input mrf_pkg::out_item_t out_data
);
	import mrf_pkg::*;

	// Stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed under stall");

	// A rejection is a lone zero byte that closes the frame
	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.rejected |-> out_data.frame_last && out_data.tx_byte == 8'h00)
		else $error("malformed rejection beat");

	// Leaving reset, the queue and the output register are empty
	a_reset_clear: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("not cleared in reset");

	// Stalled input beat holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("input beat changed under stall");

endmodule

bind modbus_rtu_request_framer_unit mrf_checker u_mrf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
